>>> src/integer_text_parser_macros.svh
// ----------------------------------------------------------------------------
// integer_text_parser_macros.svh
// Assertion macros shared by the integer text parser modules.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TEXT_PARSER_MACROS_SVH
`define INTEGER_TEXT_PARSER_MACROS_SVH

// Check a consequence in the same cycle as its cause.
`define IPAR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Check a consequence in the cycle after its cause.
`define IPAR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> src/ipar_pkg.sv
// ----------------------------------------------------------------------------
// ipar_pkg
// Types, codes and helper functions for the integer text parser.
// ----------------------------------------------------------------------------
package ipar_pkg;

    // Accumulator width and width of the result port
    localparam int VALUE_BITS = 64;
    localparam int VALUE_W    = 64;
    localparam int EFF_W      = 7;

    // Parser phases
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_LEAD   = 3'd1,
        PH_SIGNED = 3'd2,
        PH_ZERO   = 3'd3,
        PH_DIGITS = 3'd4
    } phase_t;

    // Conversion modes
    typedef enum logic [2:0] {
        MODE_SDEC = 3'd0,
        MODE_UDEC = 3'd1,
        MODE_OCT  = 3'd2,
        MODE_HEX  = 3'd3,
        MODE_AUTO = 3'd4
    } mode_t;

    // Result size codes
    localparam logic [1:0] SIZE_32 = 2'd0;
    localparam logic [1:0] SIZE_16 = 2'd1;
    localparam logic [1:0] SIZE_64 = 2'd2;

    // Characters of interest
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_LX    = 8'h78;

    // Digit value that no base accepts
    localparam logic [4:0] DIGIT_NONE = 5'd31;

    // One input beat
    typedef struct packed {
        logic [7:0] ch;
        logic       start_req;
        logic [2:0] mode;
        logic [1:0] size;
        logic [5:0] max_width;
    } ipar_item_t;

    // One result beat
    typedef struct packed {
        logic               consumed;
        logic               finished;
        logic               found;
        logic               overflow;
        logic [VALUE_W-1:0] value;
    } ipar_result_t;

    // Value of a character as a digit in any base up to sixteen
    function automatic logic [4:0] digit_of(input logic [7:0] c);
        logic [4:0] d;
        d = DIGIT_NONE;
        if (c >= CH_0 && c <= CH_9)
            d = 5'(c - CH_0);
        else if (c >= CH_LA && c <= CH_LF)
            d = 5'(c - CH_LA) + 5'd10;
        else if (c >= CH_UA && c <= CH_UF)
            d = 5'(c - CH_UA) + 5'd10;
        return d;
    endfunction

    // Radix of a resolved mode
    function automatic logic [4:0] base_of(input mode_t m);
        logic [4:0] b;
        b = 5'd10;
        if (m == MODE_OCT)
            b = 5'd8;
        else if (m == MODE_HEX)
            b = 5'd16;
        return b;
    endfunction

    // Number of result bits kept for a size code
    function automatic logic [EFF_W-1:0] eff_bits(input logic [1:0] sz);
        logic [EFF_W-1:0] bits;
        unique case (sz)
            SIZE_32: bits = EFF_W'(32);
            SIZE_16: bits = EFF_W'(16);
            default: bits = EFF_W'(64);
        endcase
        if (bits > EFF_W'(VALUE_BITS))
            bits = EFF_W'(VALUE_BITS);
        return bits;
    endfunction

endpackage

>>> src/ipar_core.sv
// ----------------------------------------------------------------------------
// ipar_core
// Parser state and the combinational step that handles one character beat.
// ----------------------------------------------------------------------------
`include "integer_text_parser_macros.svh"

module ipar_core
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step_en,
    input  ipar_pkg::ipar_item_t  item,
    output ipar_pkg::ipar_result_t res
);

    localparam int VB = ipar_pkg::VALUE_BITS;

    ipar_pkg::phase_t  phase_reg, phase_next;
    ipar_pkg::mode_t   mode_reg,  mode_next;
    logic [1:0]        size_reg,  size_next;
    logic [5:0]        width_reg, width_next;
    logic              neg_reg,   neg_next;
    logic [VB-1:0]     acc_reg,   acc_next;
    logic              seen_reg,  seen_next;
    logic              sat_reg,   sat_next;

    logic              take;
    logic              count;
    logic              reject;
    logic              fin;
    logic [4:0]        dig;
    logic [VB-1:0]     limit;
    logic [VB+3:0]     acc_x10;
    logic [VB+3:0]     dec_sum;
    logic [VB-1:0]     signed_val;
    logic [ipar_pkg::VALUE_W-1:0]   ext_val;
    logic [ipar_pkg::VALUE_W-1:0]   keep_mask;
    logic [ipar_pkg::EFF_W-1:0]     eff;
    logic              sign_bit;

    // Step one character through the field grammar
    always_comb
    begin
        phase_next = phase_reg;
        mode_next  = mode_reg;
        size_next  = size_reg;
        width_next = width_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        seen_next  = seen_reg;
        sat_next   = sat_reg;
        take       = 1'b0;
        count      = 1'b0;
        reject     = 1'b0;
        fin        = 1'b0;
        res        = '0;

        // Load a fresh field on start, dropping any field in flight
        if (item.start_req)
        begin
            if (item.mode > 3'(ipar_pkg::MODE_AUTO))
                mode_next = ipar_pkg::MODE_AUTO;
            else
                mode_next = ipar_pkg::mode_t'(item.mode);
            size_next  = item.size;
            width_next = item.max_width;
            neg_next   = 1'b0;
            acc_next   = '0;
            seen_next  = 1'b0;
            sat_next   = 1'b0;
            phase_next = ipar_pkg::PH_LEAD;
        end

        // Skip spaces, take an optional sign
        if (phase_next == ipar_pkg::PH_LEAD)
        begin
            if (item.ch == ipar_pkg::CH_SPACE)
            begin
                take = 1'b1;
            end
            else if (item.ch == ipar_pkg::CH_PLUS || item.ch == ipar_pkg::CH_MINUS)
            begin
                neg_next   = (item.ch == ipar_pkg::CH_MINUS);
                phase_next = ipar_pkg::PH_SIGNED;
                take       = 1'b1;
                count      = 1'b1;
            end
            else
            begin
                phase_next = ipar_pkg::PH_SIGNED;
            end
        end

        // Look for a leading zero, then for the x of a hex prefix
        if (!take)
        begin
            if (phase_next == ipar_pkg::PH_SIGNED)
            begin
                if (item.ch == ipar_pkg::CH_0 &&
                    (mode_next == ipar_pkg::MODE_HEX || mode_next == ipar_pkg::MODE_AUTO))
                begin
                    seen_next  = 1'b1;
                    phase_next = ipar_pkg::PH_ZERO;
                    take       = 1'b1;
                    count      = 1'b1;
                end
                else
                begin
                    if (mode_next == ipar_pkg::MODE_AUTO)
                        mode_next = ipar_pkg::MODE_UDEC;
                    phase_next = ipar_pkg::PH_DIGITS;
                end
            end
            else if (phase_next == ipar_pkg::PH_ZERO)
            begin
                if (item.ch == ipar_pkg::CH_LX || item.ch == ipar_pkg::CH_UX)
                begin
                    mode_next  = ipar_pkg::MODE_HEX;
                    phase_next = ipar_pkg::PH_DIGITS;
                    take       = 1'b1;
                    count      = 1'b1;
                end
                else
                begin
                    if (mode_next == ipar_pkg::MODE_AUTO)
                        mode_next = ipar_pkg::MODE_OCT;
                    phase_next = ipar_pkg::PH_DIGITS;
                end
            end
        end

        // Accumulate a digit or reject the character
        dig     = ipar_pkg::digit_of(item.ch);
        limit   = {1'b0, {(VB-1){1'b1}}} + VB'(neg_next);
        acc_x10 = {acc_next, 3'b000} + {1'b0, 1'b0, acc_next, 1'b0};
        dec_sum = acc_x10 + (VB+4)'(dig);
        if (!take && phase_next == ipar_pkg::PH_DIGITS)
        begin
            if (dig < ipar_pkg::base_of(mode_next))
            begin
                take      = 1'b1;
                count     = 1'b1;
                seen_next = 1'b1;
                if (mode_next == ipar_pkg::MODE_SDEC)
                begin
                    if (!sat_next)
                    begin
                        if (dec_sum > (VB+4)'(limit))
                        begin
                            sat_next = 1'b1;
                            acc_next = limit;
                        end
                        else
                        begin
                            acc_next = dec_sum[VB-1:0];
                        end
                    end
                end
                else if (mode_next == ipar_pkg::MODE_OCT)
                begin
                    acc_next = {acc_next[VB-4:0], 3'b000} + VB'(dig);
                end
                else if (mode_next == ipar_pkg::MODE_HEX)
                begin
                    acc_next = {acc_next[VB-5:0], 4'b0000} + VB'(dig);
                end
                else
                begin
                    acc_next = dec_sum[VB-1:0];
                end
            end
            else
            begin
                reject = 1'b1;
            end
        end

        // Count the width and close the field
        if (count && width_next != 6'd0)
            width_next = width_next - 6'd1;
        fin = reject || (count && width_next == 6'd0 && item.max_width != 6'd0 &&
                         item.start_req) ||
              (count && width_next == 6'd0 && !item.start_req && width_reg != 6'd0);

        // Form the result: negate, truncate to size, extend
        signed_val = neg_next ? (VB'(0) - acc_next) : acc_next;
        ext_val    = ipar_pkg::VALUE_W'(signed_val);
        eff        = ipar_pkg::eff_bits(size_next);
        keep_mask  = {ipar_pkg::VALUE_W{1'b1}} >> (ipar_pkg::EFF_W'(ipar_pkg::VALUE_W) - eff);
        ext_val    = ext_val & keep_mask;
        sign_bit   = ext_val[6'(eff - ipar_pkg::EFF_W'(1))];
        if (mode_next == ipar_pkg::MODE_SDEC && sign_bit)
            ext_val = ext_val | ~keep_mask;

        if (phase_next != ipar_pkg::PH_IDLE)
        begin
            res.consumed = take;
            if (fin)
            begin
                res.finished = 1'b1;
                res.found    = seen_next;
                res.overflow = sat_next;
                res.value    = seen_next ? ext_val : '0;
                phase_next   = ipar_pkg::PH_IDLE;
            end
        end
    end

    // Hold parser state between beats
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ipar_pkg::PH_IDLE;
            mode_reg  <= ipar_pkg::MODE_SDEC;
            size_reg  <= '0;
            width_reg <= '0;
            neg_reg   <= 1'b0;
            acc_reg   <= '0;
            seen_reg  <= 1'b0;
            sat_reg   <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
            mode_reg  <= mode_next;
            size_reg  <= size_next;
            width_reg <= width_next;
            neg_reg   <= neg_next;
            acc_reg   <= acc_next;
            seen_reg  <= seen_next;
            sat_reg   <= sat_next;
        end
    end

    `IPAR_ASSERT_NEXT(a_fin_to_idle, step_en && res.finished, phase_reg == ipar_pkg::PH_IDLE, "field end did not return to idle")
    `IPAR_ASSERT_NOW(a_idle_quiet, step_en && phase_reg == ipar_pkg::PH_IDLE && !item.start_req, res == '0, "idle parser produced a result")
    `IPAR_ASSERT_NOW(a_ovf_found, step_en && res.overflow, res.found && res.finished, "overflow without a number")

endmodule

>>> src/integer_text_parser.sv
// Path: a beat waits in the input register until the result register is free; the
// core then steps it into that register. Throughput: one character per cycle
// unless out_ready stalls; the step logic handles a whole character per beat.
// Reset: rst_n clears both valid flags and returns the parser to idle at once.
// ----------------------------------------------------------------------------
// integer_text_parser
// Streaming integer field converter: input register, step core, result register.
// ----------------------------------------------------------------------------
`include "integer_text_parser_macros.svh"

module integer_text_parser
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [7:0]                   ch,
    input  logic                         start_req,
    input  logic [2:0]                   mode,
    input  logic [1:0]                   size,
    input  logic [5:0]                   max_width,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         consumed,
    output logic                         finished,
    output logic                         found,
    output logic                         overflow,
    output logic [ipar_pkg::VALUE_W-1:0] value
);

    logic                   in_valid_reg, in_valid_next;
    ipar_pkg::ipar_item_t   item_reg;
    logic                   out_valid_reg, out_valid_next;
    ipar_pkg::ipar_result_t res_reg;
    ipar_pkg::ipar_result_t step_res;
    logic                   advance;

    // Move a beat on when the result register is free or being emptied
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_valid && in_ready)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    ipar_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .item    (item_reg),
        .res     (step_res)
    );

    // Hold valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the input beat and the stepped result
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.ch        <= ch;
            item_reg.start_req <= start_req;
            item_reg.mode      <= mode;
            item_reg.size      <= size;
            item_reg.max_width <= max_width;
        end
        if (advance)
            res_reg <= step_res;
    end

    assign out_valid = out_valid_reg;
    assign consumed  = res_reg.consumed;
    assign finished  = res_reg.finished;
    assign found     = res_reg.found;
    assign overflow  = res_reg.overflow;
    assign value     = res_reg.value;

    `IPAR_ASSERT_NEXT(a_adv_out, advance, out_valid_reg, "stepped beat missing from result register")
    `IPAR_ASSERT_NOW(a_nofind_zero, out_valid_reg && !res_reg.found, res_reg.value == '0, "value set without a number")
    `IPAR_ASSERT_NEXT(a_hold_in, in_valid_reg && !advance, in_valid_reg, "stalled input beat lost")

endmodule

>>> sim/tb_integer_text_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_text_parser
// Self-checking bench for the streaming integer field converter. A short
// table of hand-built field text comes first. Random fields follow, with
// noise beats and broken fields mixed in, while the input side sends in
// bursts and the result side stalls. Every result beat is compared with a
// typed row result or with a local model of the parser.
// ----------------------------------------------------------------------------
module tb_integer_text_parser;
    import ipar_pkg::*;

    localparam int DIRECTED_ROWS = 26;
    localparam int ITEM_TARGET   = 950;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 150;
    localparam int REPORT_LIMIT  = 10;
    localparam int ITEM_W        = $bits(ipar_item_t);

    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_NL    = 8'h0a;

    // How the model takes one character
    typedef enum logic [1:0] {
        TAKE_REJECT,
        TAKE_COUNTED,
        TAKE_FREE,
        TAKE_PENDING
    } take_t;

    // One row of directed text: the beat, then an optional typed result
    typedef struct packed {
        logic [7:0]         ch;
        logic               start_req;
        logic [2:0]         mode;
        logic [1:0]         size;
        logic [5:0]         max_width;
        logic               typed;
        logic               consumed;
        logic               finished;
        logic               found;
        logic               overflow;
        logic [VALUE_W-1:0] value;
    } text_row_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [7:0]         ch;
    logic               start_req;
    logic [2:0]         mode;
    logic [1:0]         size;
    logic [5:0]         max_width;
    logic               out_valid;
    logic               out_ready;
    logic               consumed;
    logic               finished;
    logic               found;
    logic               overflow;
    logic [VALUE_W-1:0] value;

    // Parser model state
    phase_t                parse_phase = PH_IDLE;
    mode_t                 parse_mode  = MODE_SDEC;
    logic [1:0]            parse_size  = '0;
    logic [5:0]            parse_left  = '0;
    logic                  parse_neg   = 1'b0;
    logic [VALUE_BITS-1:0] parse_acc   = '0;
    logic                  parse_digit = 1'b0;
    logic                  parse_sat   = 1'b0;

    ipar_result_t expected_beats [$];
    logic [7:0]   field_text [$];
    ipar_result_t got_beat;
    ipar_result_t want_beat;

    int sent_beats    = 0;
    int burst_left    = 0;
    int error_count   = 0;
    int beats_checked = 0;
    int fields_closed = 0;
    int width_ends    = 0;
    int saturations   = 0;
    int cycle_count   = 0;

    // Hand-built fields; typed results only where they read off directly
    text_row_t text_rows [DIRECTED_ROWS] = '{
        // idle after reset: character ignored
        '{8'h37, 1'b0, MODE_SDEC, SIZE_32, 6'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 64'd0},
        // " -42;" signed decimal, 32-bit, sign extended
        '{CH_SPACE, 1'b1, MODE_SDEC, SIZE_32, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 64'd0},
        '{CH_MINUS, 1'b0, MODE_SDEC, SIZE_32, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 64'd0},
        '{8'h34, 1'b0, MODE_SDEC, SIZE_32, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 64'd0},
        '{8'h32, 1'b0, MODE_SDEC, SIZE_32, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 64'd0},
        '{8'h3b, 1'b0, MODE_SDEC, SIZE_32, 6'd0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0,
          64'hffff_ffff_ffff_ffd6},
        // "0Xg" hex prefix with no digits
        '{CH_0, 1'b1, MODE_HEX, SIZE_16, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 64'd0},
        '{CH_UX, 1'b0, MODE_SDEC, SIZE_32, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 64'd0},
        '{8'h67, 1'b0, MODE_SDEC, SIZE_32, 6'd0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 64'd0},
        // width of one used up by the sign
        '{CH_PLUS, 1'b1, MODE_SDEC, SIZE_32, 6'd1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 64'd0},
        // " 078" with mode code 7 (automatic), size code 3, widest limit
        '{CH_SPACE, 1'b1, 3'd7, 2'd3, 6'd63, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 64'd0},
        '{CH_0, 1'b0, MODE_SDEC, SIZE_32, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 64'd0},
        '{8'h37, 1'b0, MODE_SDEC, SIZE_32, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 64'd0},
        '{8'h38, 1'b0, MODE_SDEC, SIZE_32, 6'd0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 64'd7},
        // "fF" hex, width two ends the field on the last digit
        '{CH_LF, 1'b1, MODE_HEX, SIZE_64, 6'd2, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 64'd0},
        '{CH_UF, 1'b0, MODE_SDEC, SIZE_32, 6'd0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 64'hff},
        // octal field rejected on its first character
        '{8'h5a, 1'b1, MODE_OCT, SIZE_32, 6'd0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 64'd0},
        // restart drops "1", then "-1 " wraps to 0xffff at 16 bits
        '{8'h31, 1'b1, MODE_UDEC, SIZE_16, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 64'd0},
        '{CH_MINUS, 1'b1, MODE_UDEC, SIZE_16, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 64'd0},
        '{8'h31, 1'b0, MODE_SDEC, SIZE_32, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 64'd0},
        '{CH_SPACE, 1'b0, MODE_SDEC, SIZE_32, 6'd0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 64'hffff},
        // top byte rejected in automatic mode
        '{8'hff, 1'b1, MODE_AUTO, SIZE_32, 6'd0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 64'd0},
        // idle again: null byte ignored
        '{8'h00, 1'b0, MODE_SDEC, SIZE_32, 6'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 64'd0},
        // "90\n" signed decimal at 16 bits
        '{CH_9, 1'b1, MODE_SDEC, SIZE_16, 6'd63, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 64'd0},
        '{CH_0, 1'b0, MODE_SDEC, SIZE_32, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 64'd0},
        '{CH_NL, 1'b0, MODE_SDEC, SIZE_32, 6'd0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 64'd90}
    };

    integer_text_parser dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .ch        (ch),
        .start_req (start_req),
        .mode      (mode),
        .size      (size),
        .max_width (max_width),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .consumed  (consumed),
        .finished  (finished),
        .found     (found),
        .overflow  (overflow),
        .value     (value)
    );

    // 100 MHz clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Digit value of a character, or DIGIT_NONE
    function automatic logic [4:0] char_value(input logic [7:0] c);
        logic [7:0] folded;
        folded = c | 8'h20;
        if (c >= CH_0 && c <= CH_9)
            return 5'(c - CH_0);
        if ((c >= CH_UA && c <= CH_UF) || (c >= CH_LA && c <= CH_LF))
            return 5'(folded - CH_LA) + 5'd10;
        return DIGIT_NONE;
    endfunction

    // Close the current field: trim to the size, extend, go idle
    task automatic close_field(input logic took, inout ipar_result_t r);
        logic [VALUE_W-1:0] v;
        logic [VALUE_W-1:0] keep;
        int                 bits;
        bits = (parse_size == SIZE_32) ? 32 : (parse_size == SIZE_16) ? 16 : 64;
        if (bits > VALUE_BITS)
            bits = VALUE_BITS;
        keep = (bits >= VALUE_W) ? '1 : ((VALUE_W'(1) << bits) - VALUE_W'(1));
        v = VALUE_W'(parse_neg ? ('0 - parse_acc) : parse_acc);
        v &= keep;
        if (parse_mode == MODE_SDEC && v[bits-1])
            v |= ~keep;
        r.consumed = took;
        r.finished = 1'b1;
        r.found    = parse_digit;
        r.overflow = parse_sat;
        r.value    = parse_digit ? v : '0;
        parse_phase = PH_IDLE;
    endtask

    // Advance the parser model by one character beat
    task automatic parse_beat(input ipar_item_t b, output ipar_result_t r);
        take_t                 take;
        logic [4:0]            radix;
        logic [4:0]            dig;
        logic [VALUE_BITS-1:0] lim;
        r = '0;
        if (b.start_req)
        begin
            parse_mode  = (b.mode > MODE_AUTO) ? MODE_AUTO : mode_t'(b.mode);
            parse_size  = b.size;
            parse_left  = b.max_width;
            parse_neg   = 1'b0;
            parse_acc   = '0;
            parse_digit = 1'b0;
            parse_sat   = 1'b0;
            parse_phase = PH_LEAD;
        end
        if (parse_phase != PH_IDLE)
        begin
            take = TAKE_PENDING;
            // skip spaces, take an optional sign
            if (parse_phase == PH_LEAD)
            begin
                if (b.ch == CH_SPACE)
                    take = TAKE_FREE;
                else if (b.ch == CH_PLUS || b.ch == CH_MINUS)
                begin
                    parse_neg   = (b.ch == CH_MINUS);
                    parse_phase = PH_SIGNED;
                    take        = TAKE_COUNTED;
                end
                else
                    parse_phase = PH_SIGNED;
            end
            // resolve a leading zero and an x prefix
            if (take == TAKE_PENDING)
            begin
                if (parse_phase == PH_SIGNED)
                begin
                    if (b.ch == CH_0 && (parse_mode == MODE_HEX || parse_mode == MODE_AUTO))
                    begin
                        parse_digit = 1'b1;
                        parse_phase = PH_ZERO;
                        take        = TAKE_COUNTED;
                    end
                    else
                    begin
                        if (parse_mode == MODE_AUTO)
                            parse_mode = MODE_UDEC;
                        parse_phase = PH_DIGITS;
                    end
                end
                else if (parse_phase == PH_ZERO)
                begin
                    if (b.ch == CH_LX || b.ch == CH_UX)
                    begin
                        parse_mode  = MODE_HEX;
                        parse_phase = PH_DIGITS;
                        take        = TAKE_COUNTED;
                    end
                    else
                    begin
                        if (parse_mode == MODE_AUTO)
                            parse_mode = MODE_OCT;
                        parse_phase = PH_DIGITS;
                    end
                end
            end
            // accumulate a digit; signed decimal saturates, the rest wrap
            if (take == TAKE_PENDING)
            begin
                radix = (parse_mode == MODE_OCT) ? 5'd8 : (parse_mode == MODE_HEX) ? 5'd16 : 5'd10;
                dig   = char_value(b.ch);
                if (dig >= radix)
                    take = TAKE_REJECT;
                else
                begin
                    take        = TAKE_COUNTED;
                    parse_digit = 1'b1;
                    if (parse_mode == MODE_SDEC)
                    begin
                        lim = {1'b0, {(VALUE_BITS-1){1'b1}}} + VALUE_BITS'(parse_neg);
                        if (!parse_sat)
                        begin
                            if (parse_acc > (lim - VALUE_BITS'(dig)) / VALUE_BITS'(10))
                            begin
                                parse_sat = 1'b1;
                                parse_acc = lim;
                            end
                            else
                                parse_acc = parse_acc * VALUE_BITS'(10) + VALUE_BITS'(dig);
                        end
                    end
                    else
                        parse_acc = parse_acc * VALUE_BITS'(radix) + VALUE_BITS'(dig);
                end
            end
            // close on a reject or when the width runs out
            if (take == TAKE_REJECT)
                close_field(1'b0, r);
            else
            begin
                r.consumed = 1'b1;
                if (take == TAKE_COUNTED && parse_left != 6'd0)
                begin
                    parse_left--;
                    if (parse_left == 6'd0)
                        close_field(1'b1, r);
                end
            end
        end
    endtask

    task automatic report_error(input string what, input ipar_result_t want,
                                input ipar_result_t got);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display({"%s: expected c%0b f%0b found%0b ovf%0b value %h,",
                      " got c%0b f%0b found%0b ovf%0b value %h"},
                     what, want.consumed, want.finished, want.found, want.overflow, want.value,
                     got.consumed, got.finished, got.found, got.overflow, got.value);
    endtask

    // Offer one beat, bursts separated by random gaps; queue its result
    task automatic send_beat(input ipar_item_t b, input logic typed, input ipar_result_t typed_res);
        ipar_result_t predicted;
        int           gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 160)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        ch        <= b.ch;
        start_req <= b.start_req;
        mode      <= b.mode;
        size      <= b.size;
        max_width <= b.max_width;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        parse_beat(b, predicted);
        expected_beats.push_back(typed ? typed_res : predicted);
        sent_beats++;
        burst_left--;
    endtask

    // Hold the input side until every queued result has been seen
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_beats.size() != 0);
    endtask

    // Build the text of one field: spaces, sign, prefix, digits, end
    task automatic compose_field(input logic [2:0] m);
        int         radix;
        int         n_dig;
        int         pick;
        int         d;
        logic       long_run;
        string      lim_txt;
        logic [7:0] c;
        field_text.delete();
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) field_text.push_back(CH_SPACE);
        pick = $urandom_range(0, 3);
        if (pick == 0)
            field_text.push_back(CH_PLUS);
        else if (pick == 1)
            field_text.push_back(CH_MINUS);
        radix = (m == MODE_OCT) ? 8 : (m == MODE_HEX) ? 16 : 10;
        if (m == MODE_HEX || m >= MODE_AUTO)
        begin
            pick = $urandom_range(0, 3);
            if (pick == 0)
            begin
                field_text.push_back(CH_0);
                field_text.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
                radix = 16;
            end
            else if (pick == 1)
            begin
                field_text.push_back(CH_0);
                if (m != MODE_HEX)
                    radix = 8;
            end
        end
        // signed decimal near its limit, or a digit run; long runs can saturate
        if (m == MODE_SDEC && $urandom_range(0, 3) == 0)
        begin
            lim_txt = "922337203685477580";
            for (int k = 0; k < lim_txt.len(); k++)
                field_text.push_back(lim_txt[k]);
            field_text.push_back(8'(CH_0 + $urandom_range(7, 9)));
        end
        else
        begin
            pick     = $urandom_range(0, 19);
            long_run = (pick >= 15);
            n_dig    = (pick < 2) ? 0 : long_run ? $urandom_range(15, 24) : $urandom_range(1, 6);
            repeat (n_dig)
            begin
                if (long_run && m == MODE_SDEC && $urandom_range(0, 1))
                    d = 9;
                else
                    d = $urandom_range(0, radix - 1);
                if (d < 10)
                    c = 8'(CH_0 + d);
                else
                    c = 8'(($urandom_range(0, 1) ? CH_LA : CH_UA) + d - 10);
                field_text.push_back(c);
            end
        end
        // end the field on a character, or leave it for the next start
        pick = $urandom_range(0, 19);
        if (pick < 12)
            field_text.push_back(8'($urandom_range(0, 255)));
        else if (pick < 17)
            field_text.push_back(pick == 12 ? CH_COMMA : pick == 13 ? CH_NL : CH_SPACE);
        // break the occasional field with a stray byte
        if ($urandom_range(0, 9) == 0 && field_text.size() != 0)
            field_text[$urandom_range(0, field_text.size() - 1)] = 8'($urandom_range(0, 255));
        if (field_text.size() == 0)
            field_text.push_back(8'($urandom_range(0, 255)));
    endtask

    // Result side: changing stall patterns, plus a long hold-off now and then
    initial
    begin : result_side
        int rx_cycles;
        int hold_left;
        int pattern;
        out_ready = 1'b0;
        rx_cycles = 0;
        hold_left = 0;
        pattern   = 0;
        forever
        begin
            @(posedge clk);
            rx_cycles++;
            if (rx_cycles % 64 == 0)
                pattern = $urandom_range(0, 3);
            if (rx_cycles % 2000 == 400)
                hold_left = HOLD_CYCLES;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (pattern == 0)
                out_ready <= 1'b1;
            else if (pattern == 1)
                out_ready <= ($urandom_range(0, 3) != 0);
            else if (pattern == 2)
                out_ready <= ($urandom_range(0, 3) == 0);
            else
                out_ready <= 1'($urandom_range(0, 1));
        end
    end

    // Check each result beat against the oldest queued expectation
    always @(posedge clk)
    begin
        cycle_count++;
        if (rst_n && out_valid && out_ready)
        begin
            got_beat = {consumed, finished, found, overflow, value};
            beats_checked++;
            if (expected_beats.size() == 0)
                report_error("unexpected result beat", '0, got_beat);
            else
            begin
                want_beat = expected_beats.pop_front();
                if (got_beat.consumed !== want_beat.consumed
                    || got_beat.finished !== want_beat.finished
                    || got_beat.found !== want_beat.found
                    || got_beat.overflow !== want_beat.overflow
                    || got_beat.value !== want_beat.value)
                    report_error($sformatf("result beat %0d", beats_checked), want_beat, got_beat);
            end
            if (got_beat.finished)
            begin
                fields_closed++;
                if (got_beat.overflow)
                    saturations++;
                if (got_beat.consumed)
                    width_ends++;
            end
        end
    end

    // Abort a hung run
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, expected_beats.size());
        $display("integer_text_parser verification failed");
        $finish;
    end

    // Stimulus: reset, directed table, then random fields
    initial
    begin : stimulus
        ipar_item_t   b;
        ipar_result_t typed_res;
        text_row_t    row;
        logic [2:0]   f_mode;
        logic [1:0]   f_size;
        logic [5:0]   f_width;
        int           drains_done;
        int           pick;
        in_valid    = 1'b0;
        ch          = '0;
        start_req   = 1'b0;
        mode        = '0;
        size        = '0;
        max_width   = '0;
        rst_n       = 1'b0;
        drains_done = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // walk the directed table
        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            row       = text_rows[i];
            b         = {row.ch, row.start_req, row.mode, row.size, row.max_width};
            typed_res = {row.consumed, row.finished, row.found, row.overflow, row.value};
            send_beat(b, row.typed, typed_res);
        end
        drain_results();

        // random fields, noise and broken fields
        while (sent_beats < ITEM_TARGET)
        begin
            if (drains_done < 2 && sent_beats >= 300 + 350 * drains_done)
            begin
                drain_results();
                drains_done++;
            end
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    b = ITEM_W'($urandom);
                    send_beat(b, 1'b0, '0);
                end
            end
            else
            begin
                f_mode = ($urandom_range(0, 9) < 3) ? 3'(MODE_SDEC) : 3'($urandom_range(0, 7));
                f_size = 2'($urandom_range(0, 3));
                pick   = $urandom_range(0, 19);
                f_width = (pick < 13) ? 6'd0 : (pick < 18) ? 6'($urandom_range(1, 8))
                        : (pick == 18) ? 6'd63 : 6'($urandom_range(9, 62));
                compose_field(f_mode);
                for (int k = 0; k < field_text.size(); k++)
                begin
                    b           = ITEM_W'($urandom);
                    b.ch        = field_text[k];
                    b.start_req = (k == 0);
                    if (k == 0)
                    begin
                        b.mode      = f_mode;
                        b.size      = f_size;
                        b.max_width = f_width;
                    end
                    send_beat(b, 1'b0, '0);
                end
            end
        end

        // wait out the tail, then report
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_beats.size() != 0)
            report_error("result beat never arrived", expected_beats[0], '0);
        $display("checked %0d result beats over %0d input beats in %0d cycles",
                 beats_checked, sent_beats, cycle_count);
        $display("fields closed %0d: %0d by width limit, %0d saturated, %0d errors",
                 fields_closed, width_ends, saturations, error_count);
        if (error_count == 0)
            $display("integer_text_parser verification clean");
        else
            $display("integer_text_parser verification failed");
        $finish;
    end

endmodule
